// ===== hw/rtl/tfrd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfrd_pkg
// Shared types and constants for the token framed reading deframer.
// ----------------------------------------------------------------------------
package tfrd_pkg;

  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN + 1);
  localparam int unsigned NUM_READ  = 4;
  localparam logic signed [15:0] HUNDRED = 16'sd100;

  localparam logic [7:0] OPEN_TOK_RST  = 8'd2;
  localparam logic [7:0] CLOSE_TOK_RST = 8'd3;
  localparam logic [7:0] PADDING_RST   = 8'd0;

  typedef enum logic [1:0] {
    REG_OPEN_TOK  = 2'd0,
    REG_CLOSE_TOK = 2'd1,
    REG_PADDING   = 2'd2
  } cfg_reg_t;

  // byte 0 at index 0
  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic        [15:0] mode_word;
    logic signed [15:0] reading_current;
    logic signed [15:0] reading_max;
    logic signed [15:0] reading_min;
    logic signed [15:0] reading_mean;
  } msg_t;

endpackage

// ===== hw/rtl/token_framed_reading_deframer.sv =====
// ----------------------------------------------------------------------------
// token_framed_reading_deframer
// Collects bytes between start and end tokens and decodes ten-byte frames.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while in_stall is low. A word in the input
// register updates the frame store, write position and overrun flag; an end
// token that closes a complete frame loads the decoded message into the output
// register, so out_valid rises once the word has passed through the input
// register and then the output register. in_stall is raised only when an end
// token that completes a frame waits in the input register while the output
// register still holds an untaken, stalled message. Configuration writes take
// effect at the next edge and are meant to happen only while no word is in flight.
module token_framed_reading_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [15:0] mode_word,
  output logic signed [15:0] reading_current,
  output logic signed [15:0] reading_max,
  output logic signed [15:0] reading_min,
  output logic signed [15:0] reading_mean
);
  import tfrd_pkg::*;

  logic [7:0]       open_tok;
  logic [7:0]       close_tok;
  logic [7:0]       pad_offset;

  logic             s1_valid;
  logic [7:0]       s1_byte;

  frame_t           frame_store;
  logic [POS_W-1:0] write_position;
  logic [POS_W-1:0] write_position_next;
  logic             overrun_flag;
  logic             overrun_flag_next;

  logic             is_start;
  logic             is_end;
  logic             emit;
  logic             s1_go;
  logic             store_we;

  msg_t             dec_msg;
  msg_t             out_msg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_tok   <= OPEN_TOK_RST;
      close_tok  <= CLOSE_TOK_RST;
      pad_offset <= PADDING_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OPEN_TOK:  open_tok   <= cfg_data;
        REG_CLOSE_TOK: close_tok  <= cfg_data;
        REG_PADDING:   pad_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // start token wins when both tokens match
  assign is_start = (s1_byte == open_tok);
  assign is_end   = !is_start && (s1_byte == close_tok);
  assign emit     = is_end && (write_position == POS_W'(FRAME_LEN)) && !overrun_flag;

  assign s1_go    = s1_valid && (!emit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  assign store_we = s1_go && !is_start && !is_end
                    && (write_position < POS_W'(FRAME_LEN));

  always_comb begin
    write_position_next = write_position;
    overrun_flag_next   = overrun_flag;
    if (s1_go) begin
      if (is_start) begin
        write_position_next = '0;
        overrun_flag_next   = 1'b0;
      end else if (is_end) begin
        if (emit) begin
          write_position_next = '0;
        end
      end else if (write_position < POS_W'(FRAME_LEN)) begin
        write_position_next = write_position + POS_W'(1);
      end else begin
        overrun_flag_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      overrun_flag   <= 1'b0;
    end else begin
      write_position <= write_position_next;
      overrun_flag   <= overrun_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store[write_position] <= s1_byte;
    end
  end

  tfrd_decode u_decode (
    .frame   (frame_store),
    .padding (pad_offset),
    .msg     (dec_msg)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_msg <= dec_msg;
    end
  end

  assign mode_word       = out_msg.mode_word;
  assign reading_current = out_msg.reading_current;
  assign reading_max     = out_msg.reading_max;
  assign reading_min     = out_msg.reading_min;
  assign reading_mean    = out_msg.reading_mean;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    write_position <= POS_W'(FRAME_LEN))
    else $error("write position beyond frame length");

  a_overrun_full: assert property (@(posedge clk) disable iff (rst)
    overrun_flag |-> (write_position == POS_W'(FRAME_LEN)))
    else $error("overrun set with partial frame");

  a_emit_rewind: assert property (@(posedge clk) disable iff (rst)
    (s1_go && emit) |=> (write_position == '0) && out_valid)
    else $error("emitted frame did not rewind or show result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (emit && out_valid && out_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule

// ===== hw/rtl/tfrd_decode.sv =====
// ----------------------------------------------------------------------------
// tfrd_decode
// Turns a full ten-byte frame into the mode word and four readings.
// ----------------------------------------------------------------------------
module tfrd_decode (
  input  tfrd_pkg::frame_t   frame,
  input  logic [7:0]         padding,
  output tfrd_pkg::msg_t     msg
);
  import tfrd_pkg::*;

  logic signed [8:0]  whole [NUM_READ];
  logic signed [8:0]  part  [NUM_READ];
  logic signed [15:0] value [NUM_READ];

  // reading = (int byte - padding) * 100 + (frac byte - padding)
  always_comb begin
    for (int i = 0; i < NUM_READ; i++) begin
      whole[i] = $signed({1'b0, frame[2 + 2*i]})     - $signed({1'b0, padding});
      part[i]  = $signed({1'b0, frame[2 + 2*i + 1]}) - $signed({1'b0, padding});
      value[i] = 16'(whole[i]) * HUNDRED + 16'(part[i]);
    end
  end

  always_comb begin
    msg.mode_word       = {frame[0], frame[1]};
    msg.reading_current = value[0];
    msg.reading_max     = value[1];
    msg.reading_min     = value[2];
    msg.reading_mean    = value[3];
  end

endmodule
